/* sv/smip_pkg.sv */
// Package for the servo motion interpolator: function codes, widths and reset values.
// No dependencies.
package smip_pkg;
  localparam int unsigned NumChannels = 8;
  localparam int unsigned ChanW = 3;
  localparam int unsigned PulseW = 12;
  localparam int unsigned TickMsDefault = 20;
  localparam logic [PulseW-1:0] PulseReset = 12'd1500;
  localparam logic [15:0] MoveTimeReset = 16'd2000;

  localparam logic [2:0] FuncTick = 3'd0;
  localparam logic [2:0] FuncSetPulse = 3'd1;
  localparam logic [2:0] FuncSetAngle = 3'd2;
  localparam logic [2:0] FuncAllMid = 3'd3;
  localparam logic [2:0] FuncAllOff = 3'd4;
  localparam logic [2:0] FuncSlot = 3'd5;

  localparam logic [1:0] RegMinPulse = 2'd0;
  localparam logic [1:0] RegMaxPulse = 2'd1;
  localparam logic [1:0] RegMidPulse = 2'd2;
  localparam logic [1:0] RegSlotUs = 2'd3;
endpackage

/* sv/smip_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module smip_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* sv/servo_motion_interpolator_pwm.sv */
// Top level of the eight-channel servo pulse controller with linear interpolation.
// Depends on smip_pkg and smip_ram.
// One transaction at a time; the next is taken in the cycle after the result register loads.
// Asynchronous reset; the target and current RAMs are then filled with 1500.
module servo_motion_interpolator_pwm #(
  parameter int unsigned TickMs = smip_pkg::TickMsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[2:0], servo_id[10:3], pulse_us[26:11], angle_deg[42:27], move_ms[58:43]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot_channel[2:0], pin_level[3], pin_present[4], reload_value[20:5],
  // moving[21], target_readback[33:22]
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import smip_pkg::*;

  localparam logic [20:0] AngRecip = 21'd1491309;
  localparam longint unsigned TickRecipL =
    ((64'd1 << 26) + 64'(TickMs) - 64'd1) / 64'(TickMs);
  localparam logic [26:0] TickRecip = 27'(TickRecipL);

  typedef enum logic [3:0] {
    StInit, StIdle, StRead, StExec, StBulk, StTkRd, StTkDiv, StTkWr, StOut
  } state_e;

  typedef struct packed {
    logic       we;
    logic [2:0] addr;
    logic [11:0] data;
  } wr_t;

  state_e      state_q;
  logic [11:0] min_q, max_q, mid_q;
  logic [15:0] slot_us_q;
  logic [11:0] step_total_q, steps_left_q;
  logic [15:0] move_time_q;
  logic        running_q, pending_q;
  logic [4:0]  phase_q;
  logic [2:0]  func_q;
  logic [7:0]  id_q;
  logic [15:0] pulse_q, angle_q, ms_q;
  logic [2:0]  ch_q;
  logic [4:0]  cnt_q;
  logic [23:0] num_q;
  logic [23:0] quo_q;
  logic [12:0] rem_q;
  logic        neg_q;
  logic [11:0] tgt_lat_q;
  logic [39:0] out_q;
  logic        out_v_q;
  logic [20:0] slot_q;
  logic [11:0] ang_pulse_q;
  logic [7:0]  ang_cnt_q;

  wr_t         tw, cw, sw;
  logic [2:0]  tra, cra, sra;
  logic [11:0] tgt_rd, cur_rd, st_rd;

  smip_ram #(.Width(PulseW), .Depth(NumChannels)) u_tgt (
    .clk_i, .we_i(tw.we), .waddr_i(tw.addr), .wdata_i(tw.data), .raddr_i(tra), .rdata_o(tgt_rd));
  smip_ram #(.Width(PulseW), .Depth(NumChannels)) u_cur (
    .clk_i, .we_i(cw.we), .waddr_i(cw.addr), .wdata_i(cw.data), .raddr_i(cra), .rdata_o(cur_rd));
  smip_ram #(.Width(PulseW), .Depth(NumChannels)) u_st (
    .clk_i, .we_i(sw.we), .waddr_i(sw.addr), .wdata_i(sw.data), .raddr_i(sra), .rdata_o(st_rd));

  // Configuration port.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  always_comb begin
    case (paddr[3:2])
      RegMinPulse: prdata = {20'd0, min_q};
      RegMaxPulse: prdata = {20'd0, max_q};
      RegMidPulse: prdata = {20'd0, mid_q};
      default:     prdata = {16'd0, slot_us_q};
    endcase
  end

  logic id_ok;
  assign id_ok = (id_q >= 8'd1) && (id_q <= 8'd6);
  logic [2:0] id3;
  assign id3 = id_q[2:0];

  // Clamped set-pulse or set-angle value and move time.
  logic [15:0] req;
  logic [11:0] clamped;
  logic [15:0] ms_cl;
  always_comb begin
    req = (func_q == FuncSetAngle) ? {4'd0, ang_pulse_q} : pulse_q;
    if (req < {4'd0, min_q}) req = {4'd0, min_q};
    if (req > {4'd0, max_q}) req = {4'd0, max_q};
    clamped = req[11:0];
    ms_cl = ms_q;
    if (ms_cl < 16'd20) ms_cl = 16'd20;
    if (ms_cl > 16'd30000) ms_cl = 16'd30000;
  end

  // Angle: span*angle/180 by multiplying with a scaled reciprocal of 180.
  logic [11:0] span;
  logic [7:0]  ang_cl;
  logic [40:0] ang_prod;
  logic [11:0] ang_quo;
  assign span = (max_q >= min_q) ? max_q - min_q : 12'd0;
  assign ang_cl = (angle_q > 16'd180) ? 8'd180 : angle_q[7:0];
  assign ang_prod = {21'd0, num_q[19:0]} * {20'd0, AngRecip};
  assign ang_quo = ang_prod[39:28];

  // Steps from move time; division by the tick constant through its scaled reciprocal.
  logic [41:0] steps_prod;
  logic [15:0] steps_raw;
  logic [11:0] steps_cl;
  assign steps_prod = {26'd0, move_time_q} * {15'd0, TickRecip};
  assign steps_raw = steps_prod[41:26];
  assign steps_cl = (steps_raw == 16'd0) ? 12'd1 :
                    (steps_raw > 16'd4095) ? 12'd4095 : steps_raw[11:0];

  // Restoring divide step of |num| by step_total.
  logic [12:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem_q[11:0], num_q[23]};
  assign q_bit  = rem_sh >= {1'b0, step_total_q};

  logic [12:0] diff;
  logic [24:0] prod;
  assign diff = {1'b0, (pending_q ? cur_rd : st_rd)} - {1'b0, tgt_rd};
  assign prod = $signed(diff) * $signed({1'b0, steps_left_q});

  logic [24:0] qsigned;
  logic [23:0] qmag;
  assign qmag = quo_q + ((neg_q && rem_q != 13'd0) ? 24'd1 : 24'd0);
  assign qsigned = neg_q ? -{1'b0, qmag} : {1'b0, qmag};

  logic [4:0]  ph_n;
  logic [2:0]  sch;
  logic        sch_pin;
  assign ph_n = (phase_q == 5'd16) ? 5'd1 : phase_q + 5'd1;
  assign sch = ph_n[3:1] - {2'd0, ~ph_n[0]} ;
  assign sch_pin = (sch >= 3'd1) && (sch <= 3'd6);

  // Memory port control.
  always_comb begin
    tw = '0; cw = '0; sw = '0;
    tra = id3; cra = sch; sra = ch_q;
    case (state_q)
      StInit: begin
        tw = '{we: 1'b1, addr: ch_q, data: PulseReset};
        cw = '{we: 1'b1, addr: ch_q, data: PulseReset};
      end
      StIdle: begin
        tra = s_axis_tdata[5:3];
      end
      StExec: begin
        if ((func_q == FuncSetPulse || func_q == FuncSetAngle) && id_ok) begin
          tw = '{we: 1'b1, addr: id3, data: clamped};
        end
      end
      StBulk: begin
        if (ch_q >= 3'd1 && ch_q <= 3'd6) begin
          tw = '{we: 1'b1, addr: ch_q,
                 data: (func_q == FuncAllMid) ? mid_q : 12'd0};
          cw = '{we: func_q == FuncAllOff, addr: ch_q, data: 12'd0};
        end
      end
      StTkRd: begin
        tra = ch_q; cra = ch_q; sra = ch_q;
        if (cnt_q == 5'd1 && pending_q) begin
          sw = '{we: 1'b1, addr: ch_q, data: cur_rd};
        end
      end
      StTkWr: begin
        tra = id3;
        cw = '{we: 1'b1, addr: ch_q,
               data: (steps_left_q == 12'd0) ? tgt_lat_q :
                     tgt_lat_q + qsigned[11:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      min_q <= 12'd500; max_q <= 12'd2500; mid_q <= 12'd1500; slot_us_q <= 16'd2500;
      step_total_q <= '0; steps_left_q <= '0; move_time_q <= MoveTimeReset;
      running_q <= 1'b0; pending_q <= 1'b0; phase_q <= '0;
      ch_q <= '0; cnt_q <= '0; out_v_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          RegMinPulse: min_q <= pwdata[11:0];
          RegMaxPulse: max_q <= pwdata[11:0];
          RegMidPulse: mid_q <= pwdata[11:0];
          RegSlotUs:   slot_us_q <= pwdata[15:0];
          default: ;
        endcase
      end
      if (out_v_q && m_axis_tready && state_q != StOut) out_v_q <= 1'b0;
      case (state_q)
        StInit: begin
          ch_q <= ch_q + 3'd1;
          if (ch_q == 3'd7) state_q <= StIdle;
        end
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            func_q <= s_axis_tdata[2:0];
            id_q <= s_axis_tdata[10:3];
            pulse_q <= s_axis_tdata[26:11];
            angle_q <= s_axis_tdata[42:27];
            ms_q <= s_axis_tdata[58:43];
            ch_q <= '0;
            cnt_q <= '0;
            ang_cnt_q <= 8'd12;
            ang_pulse_q <= '0;
            num_q <= '0;
            state_q <= StRead;
          end
        end
        StRead: begin
          if (func_q == FuncSetAngle && ang_cnt_q == 8'd12) begin
            num_q <= {4'd0, {8'd0, span} * {12'd0, ang_cl}};
            ang_cnt_q <= 8'd1;
          end else begin
            if (func_q == FuncSetAngle) ang_pulse_q <= ang_quo + min_q;
            state_q <= StExec;
          end
        end
        StExec: begin
          case (func_q)
            FuncSetPulse, FuncSetAngle: begin
              if (id_ok) begin
                move_time_q <= ms_cl;
                pending_q <= 1'b1;
              end
              state_q <= StOut;
            end
            FuncAllMid, FuncAllOff: begin
              ch_q <= '0;
              state_q <= StBulk;
            end
            FuncTick: begin
              if (pending_q) begin
                step_total_q <= steps_cl;
                steps_left_q <= steps_cl - 12'd1;
                running_q <= 1'b1;
                ch_q <= '0; cnt_q <= '0;
                state_q <= StTkRd;
              end else if (running_q) begin
                if (steps_left_q != 12'd0) steps_left_q <= steps_left_q - 12'd1;
                ch_q <= '0; cnt_q <= '0;
                state_q <= StTkRd;
              end else begin
                state_q <= StOut;
              end
            end
            FuncSlot: begin
              phase_q <= (ph_n == 5'd16) ? 5'd0 : ph_n;
              slot_q[2:0] <= sch;
              slot_q[3] <= ph_n[0] && sch_pin && (cur_rd != 12'd0);
              slot_q[4] <= sch_pin;
              slot_q[20:5] <= ph_n[0] ? ({4'd0, cur_rd} - 16'd1) :
                              (slot_us_q - {4'd0, cur_rd} - 16'd1);
              state_q <= StOut;
            end
            default: state_q <= StOut;
          endcase
        end
        StBulk: begin
          ch_q <= ch_q + 3'd1;
          if (ch_q == 3'd7) begin
            if (func_q == FuncAllMid) begin
              move_time_q <= ms_q;
              pending_q <= 1'b1;
            end else begin
              running_q <= 1'b0;
              pending_q <= 1'b0;
            end
            state_q <= StOut;
          end
        end
        StTkRd: begin
          // cnt 0: address issued; cnt 1: data valid.
          if (cnt_q == 5'd0) begin
            cnt_q <= 5'd1;
          end else begin
            tgt_lat_q <= tgt_rd;
            neg_q <= prod[24];
            num_q <= prod[24] ? 24'(-prod) : prod[23:0];
            rem_q <= '0; quo_q <= '0;
            cnt_q <= 5'd24;
            state_q <= StTkDiv;
          end
        end
        StTkDiv: begin
          num_q <= {num_q[22:0], 1'b0};
          rem_q <= q_bit ? rem_sh - {1'b0, step_total_q} : rem_sh;
          quo_q <= {quo_q[22:0], q_bit};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd1) state_q <= StTkWr;
        end
        StTkWr: begin
          ch_q <= ch_q + 3'd1;
          cnt_q <= '0;
          if (ch_q == 3'd7) begin
            pending_q <= 1'b0;
            if (steps_left_q == 12'd0) running_q <= 1'b0;
            state_q <= StOut;
          end else begin
            state_q <= StTkRd;
          end
        end
        StOut: begin
          if (!out_v_q || m_axis_tready) begin
            out_v_q <= 1'b1;
            out_q <= {6'd0,
                      id_ok ? (((func_q == FuncSetPulse) || (func_q == FuncSetAngle)) ?
                               clamped : tgt_rd) : 12'd0,
                      running_q,
                      (func_q == FuncSlot) ? slot_q : 21'd0};
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni) out_v_q && !m_axis_tready |=> out_v_q;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("accept while busy");

  a_pending_not_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StTkWr && ch_q == 3'd7 |=> !pending_q) else $error("pending kept");
endmodule

/* tb/servo_motion_interpolator_pwm_checker.sv */
// Checker for the servo pulse controller: predicts each output transaction from the accepted
// input transactions and the APB register writes, then compares it field by field.
// Depends on smip_pkg.
module servo_motion_interpolator_pwm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import smip_pkg::*;

  localparam int TickMs = TickMsDefault;

  logic [11:0] min_us, max_us, mid_us;
  logic [15:0] slot_len;
  logic [11:0] tgt[NumChannels];
  logic [11:0] cur[NumChannels];
  logic [11:0] origin[NumChannels];
  int          steps_total, steps_rem, move_ms;
  logic        running, pending;
  int          phase;
  logic [39:0] expected_q[$];
  int          errors;

  assign errors_o = errors;
  assign outstanding_o = expected_q.size();

  task automatic set_target(input int id, input int pw, input int ms);
    if (id < 1 || id > 6) return;
    if (pw < min_us) pw = min_us;
    if (pw > max_us) pw = max_us;
    if (ms < 20) ms = 20;
    if (ms > 30000) ms = 30000;
    tgt[id] = pw[11:0];
    move_ms = ms;
    pending = 1'b1;
  endtask

  task automatic advance_move();
    int steps, num, q;
    if (pending) begin
      steps = move_ms / TickMs;
      pending = 1'b0;
      if (steps == 0) steps = 1;
      if (steps > 4095) steps = 4095;
      steps_total = steps;
      steps_rem = steps;
      for (int i = 0; i < NumChannels; i++) origin[i] = cur[i];
      running = 1'b1;
    end
    if (!running) return;
    if (steps_rem > 0) steps_rem--;
    for (int i = 0; i < NumChannels; i++) begin
      if (steps_rem == 0 || steps_total == 0) begin
        cur[i] = tgt[i];
      end else begin
        num = (int'(origin[i]) - int'(tgt[i])) * steps_rem;
        q = (num >= 0) ? num / steps_total : -((-num + steps_total - 1) / steps_total);
        cur[i] = 12'(int'(tgt[i]) + q);
      end
    end
    if (steps_rem == 0) running = 1'b0;
  endtask

  task automatic predict_result(input logic [63:0] d, output logic [39:0] r);
    logic [2:0]  fn;
    int          id, pw, ang, ms, span, c, lvl, pres;
    logic [15:0] rel;
    fn = d[2:0];
    id = d[10:3];
    pw = d[26:11];
    ang = d[42:27];
    ms = d[58:43];
    c = 0;
    lvl = 0;
    pres = 0;
    rel = '0;
    case (fn)
      FuncTick: advance_move();
      FuncSetPulse: set_target(id, pw, ms);
      FuncSetAngle: begin
        span = (max_us >= min_us) ? int'(max_us) - int'(min_us) : 0;
        if (ang > 180) ang = 180;
        set_target(id, int'(min_us) + span * ang / 180, ms);
      end
      FuncAllMid: begin
        for (int i = 1; i <= 6; i++) tgt[i] = mid_us;
        move_ms = ms;
        pending = 1'b1;
      end
      FuncAllOff: begin
        for (int i = 1; i <= 6; i++) begin
          tgt[i] = '0;
          cur[i] = '0;
        end
        running = 1'b0;
        pending = 1'b0;
      end
      FuncSlot: begin
        phase++;
        if (phase > 16) phase = 1;
        c = (phase - 1) >> 1;
        pres = (c >= 1 && c <= 6);
        if (phase[0]) begin
          lvl = pres && cur[c] != 0;
          rel = 16'(int'(cur[c]) - 1);
        end else begin
          rel = 16'(int'(slot_len) - int'(cur[c]) - 1);
        end
        if (phase == 16) phase = 0;
      end
      default: ;
    endcase
    r = '0;
    r[2:0] = c[2:0];
    r[3] = lvl[0];
    r[4] = pres[0];
    r[20:5] = rel;
    r[21] = running;
    r[33:22] = (id >= 1 && id <= 6) ? tgt[id] : 12'd0;
  endtask

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [39:0] e, r;
    if (!rst_ni) begin
      min_us <= 12'd500;
      max_us <= 12'd2500;
      mid_us <= 12'd1500;
      slot_len <= 16'd2500;
      for (int i = 0; i < NumChannels; i++) begin
        tgt[i] = PulseReset;
        cur[i] = PulseReset;
        origin[i] = '0;
      end
      steps_total = 0;
      steps_rem = 0;
      move_ms = MoveTimeReset;
      running = 1'b0;
      pending = 1'b0;
      phase = 0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $realtime, m_axis_tdata);
        end else begin
          e = expected_q.pop_front();
          r = m_axis_tdata;
          compare_field("slot_channel", e[2:0], r[2:0]);
          compare_field("pin_level", e[3], r[3]);
          compare_field("pin_present", e[4], r[4]);
          compare_field("reload_value", e[20:5], r[20:5]);
          compare_field("moving", e[21], r[21]);
          compare_field("target_readback", e[33:22], r[33:22]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_result(s_axis_tdata, e);
        expected_q.push_back(e);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegMinPulse: min_us <= pwdata[11:0];
          RegMaxPulse: max_us <= pwdata[11:0];
          RegMidPulse: mid_us <= pwdata[11:0];
          RegSlotUs: slot_len <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end
endmodule

/* tb/servo_motion_interpolator_pwm_tb.sv */
// Testbench top for the servo pulse controller: clock, reset, stream stimulus with random
// gaps and stalls, APB register phases and the verdict.
// Depends on smip_pkg, servo_motion_interpolator_pwm and servo_motion_interpolator_pwm_checker.
module servo_motion_interpolator_pwm_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smip_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, outstanding;
  int          items_sent, ticks_sent, slots_sent, results_seen;
  bit          feed_busy;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  servo_motion_interpolator_pwm DUT (.*);

  servo_motion_interpolator_pwm_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors_o(errors), .outstanding_o(outstanding)
  );

  function automatic int pick_gap(input bit busy);
    int r;
    r = $urandom_range(0, 99);
    if (busy || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(input logic [2:0] fn, input int id, input int pw, input int ang,
                      input int ms);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, ms[15:0], ang[15:0], pw[15:0], id[7:0], fn};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (fn == FuncTick) ticks_sent++;
    if (fn == FuncSlot) slots_sent++;
    gap = pick_gap(feed_busy);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic random_item();
    int r, id, pw, ms;
    r = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(0, 255);
    pw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(300, 2800);
    ms = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 200);
    if (r < 30) send(FuncTick, id, pw, $urandom_range(0, 65535), ms);
    else if (r < 60) send(FuncSlot, id, pw, $urandom_range(0, 65535), ms);
    else if (r < 75) send(FuncSetPulse, id, pw, $urandom_range(0, 65535), ms);
    else if (r < 90) send(FuncSetAngle, id, pw,
                          ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 180), ms);
    else if (r < 94) send(FuncAllMid, id, pw, $urandom_range(0, 65535), ms);
    else if (r < 97) send(FuncAllOff, id, pw, $urandom_range(0, 65535), ms);
    else send(3'($urandom_range(6, 7)), id, pw, $urandom_range(0, 65535), ms);
  endtask

  // Result side: random stalls, two long hold-offs to back the block up.
  initial begin
    int hold;
    bit steady;
    steady = 1'b0;
    forever begin
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      results_seen++;
      if (results_seen % 200 == 0) steady = ~steady;
      hold = (results_seen == 100 || results_seen == 900) ? 400 : pick_gap(steady);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  initial begin
    #20ms;
    $display("servo_motion_interpolator_pwm regression: fail");
    $finish;
  end

  initial begin
    int cfg[4][4];
    cfg = '{'{0, 4095, 0, 1}, '{3000, 1000, 4095, 65535},
            '{0, 0, 0, 0}, '{800, 2200, 1500, 2000}};
    for (int k = 0; k < 4; k++) cfg[2][k] = $urandom_range(0, (k == 3) ? 65535 : 4095);
    if (cfg[2][3] == 0) cfg[2][3] = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(FuncTick, 1, 0, 0, 0);
    send(FuncSlot, 0, 0, 0, 0);
    send(FuncSlot, 0, 0, 0, 0);
    send(FuncSetPulse, 1, 0, 0, 0);
    send(FuncSetPulse, 6, 65535, 65535, 65535);
    send(FuncSetPulse, 0, 1000, 0, 100);
    send(FuncSetPulse, 7, 1000, 0, 100);
    send(FuncSetPulse, 255, 1000, 0, 100);
    send(FuncSetAngle, 2, 0, 0, 40);
    send(FuncSetAngle, 3, 0, 180, 60);
    send(FuncSetAngle, 4, 0, 65535, 19);
    for (int i = 0; i < 3; i++) send(FuncTick, 4, 0, 0, 0);
    for (int i = 0; i < 4; i++) send(FuncSlot, 2, 0, 0, 0);
    send(FuncAllMid, 5, 0, 0, 0);
    send(FuncTick, 5, 0, 0, 0);
    send(FuncAllOff, 1, 0, 0, 0);
    for (int i = 0; i < 4; i++) send(FuncSlot, 1, 0, 0, 0);
    send(3'd6, 3, 65535, 65535, 65535);
    send(3'd7, 3, 65535, 65535, 65535);

    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        wait_idle();
        write_reg(RegMinPulse, cfg[p-1][0]);
        write_reg(RegMaxPulse, cfg[p-1][1]);
        write_reg(RegMidPulse, cfg[p-1][2]);
        write_reg(RegSlotUs, cfg[p-1][3]);
      end
      for (int n = 0; n < 305; n++) begin
        if (n % 100 == 0) feed_busy = $urandom_range(0, 1);
        random_item();
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (250) @(posedge clk_i);
    $display("Covered %0d transactions (%0d ticks, %0d slot events) under five register sets,",
             items_sent, ticks_sent, slots_sent);
    $display("with %0d results checked through random stalls and long hold-offs.", results_seen);
    if (errors == 0 && outstanding == 0) begin
      $display("servo_motion_interpolator_pwm regression: pass");
    end else begin
      $display("servo_motion_interpolator_pwm regression: fail");
    end
    $finish;
  end
endmodule
